### design/bcpm_pkg.sv
// Package for the button chord priority map: sizes, field widths, codes and shared types.
// Depends on nothing; every other file of the block imports it.
package bcpm_pkg;

	// Table sizing.
	localparam int BUTTON_COUNT   = 32;
	localparam int ENTRY_CAPACITY = 1024;

	// Field widths of the words on the two channels.
	localparam int FUNC_W = 1;
	localparam int BTN_W  = 5;
	localparam int MASK_W = 32;
	localparam int CMD_W  = 12;
	localparam int ST_W   = 2;

	// Derived widths: a link holds slot number plus one, zero meaning end of list.
	localparam int SLOT_W     = $clog2(ENTRY_CAPACITY);
	localparam int LINK_W     = $clog2(ENTRY_CAPACITY + 1);
	localparam int HEAD_IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
	localparam int POP_W      = $clog2(MASK_W + 1);

	// Population count chain: each cell counts CELL_BITS bits of the mask.
	localparam int CELL_BITS  = 8;
	localparam int CELL_COUNT = MASK_W / CELL_BITS;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FN_ADD  = 1'b0;
	localparam logic [FUNC_W-1:0] FN_FIND = 1'b1;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_MISS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	// Token travelling along the population count chain.
	typedef struct packed {
		logic              v;
		logic [POP_W-1:0]  cnt;
		logic [MASK_W-1:0] bits;
	} pop_tok_t;

	// One stored chord entry; pop caches the popcount of mask.
	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [CMD_W-1:0]  cmd;
		logic [POP_W-1:0]  pop;
		logic [LINK_W-1:0] link;
	} entry_t;

	// Write request to the entry store; link_only updates just the link field.
	typedef struct packed {
		logic              en;
		logic              link_only;
		logic [SLOT_W-1:0] addr;
		entry_t            ent;
	} ent_wr_t;

	// Read request to the entry store; the data is registered and appears in the cycle after the request.
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
	} ent_rd_t;

endpackage

### design/bcpm_channels.sv
// Handshake channels of the button chord priority map: request word in, response word out.
// Depends on bcpm_pkg for the field widths.
interface bcpm_req_if;
	import bcpm_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [BTN_W-1:0]  button;
	logic [MASK_W-1:0] modifier_mask;
	logic [CMD_W-1:0]  command;

	modport source (output valid, output func, output button, output modifier_mask,
		output command, input ready);
	modport sink (input valid, input func, input button, input modifier_mask,
		input command, output ready);
endinterface

interface bcpm_rsp_if;
	import bcpm_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] found_command;
	logic [ST_W-1:0]  status;

	modport source (output valid, output found_command, output status, input ready);
	modport sink (input valid, input found_command, input status, output ready);
endinterface

### design/button_chord_priority_map.sv
// Top level of the button chord priority map: sequencer, list heads, popcount chain and
// response register. Depends on bcpm_pkg, bcpm_channels, bcpm_pop_cell and bcpm_entry_store.
//
// One request word is taken at a time and gives exactly one response word. An add word
// first runs its mask through the popcount chain of CELL_COUNT cells, which it enters
// directly on acceptance, then walks the button's list with a read of the entry store
// and a compare for each entry passed, plus a read, or a read and a compare, for the
// place where the walk stops. It then writes the new entry, relinks its predecessor
// when it is not inserted at the head, and posts the response. A find word is accepted,
// reads and compares each entry in turn until one hits, then posts the response; a
// miss spends one more read on the end of the list. The single registered read port
// of the entry store is why each entry passed takes both a read and a compare. A new
// word is taken in the cycle after the response of the last one has moved into the
// output register, while that response may still wait to be taken.
module button_chord_priority_map (
	input logic clk,
	input logic arst_n,
	bcpm_req_if.sink   req,
	bcpm_rsp_if.source rsp
);
	import bcpm_pkg::*;

	// Sequencer state codes.
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_POP      = 3'd1;
	localparam logic [2:0] S_RD       = 3'd2;
	localparam logic [2:0] S_CHK      = 3'd3;
	localparam logic [2:0] S_INS_NEW  = 3'd4;
	localparam logic [2:0] S_INS_LINK = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	logic [2:0]        state_q;
	logic [FUNC_W-1:0] func_q;
	logic [BTN_W-1:0]  button_q;
	logic [MASK_W-1:0] mask_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [POP_W-1:0]  bits_q;
	logic [LINK_W-1:0] cur_q;
	logic [LINK_W-1:0] prev_q;
	logic [LINK_W-1:0] used_q;
	logic [LINK_W-1:0] heads_q [BUTTON_COUNT];
	logic [CMD_W-1:0]  res_cmd_q;
	logic [ST_W-1:0]   res_st_q;
	logic              out_valid_q;
	logic [CMD_W-1:0]  out_cmd_q;
	logic [ST_W-1:0]   out_st_q;

	logic              accept;
	logic              in_range;
	logic              table_full;
	logic              add_go;
	logic [LINK_W-1:0] head_in;
	logic              cur_ok;
	logic [LINK_W-1:0] new_link;
	logic              subset_hit;
	logic              out_free;
	pop_tok_t          chain_tok [CELL_COUNT + 1];
	ent_wr_t           wr;
	ent_rd_t           rd;
	entry_t            rd_data;

	// Handshake and request decode.
	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign in_range   = {1'b0, req.button} < (BTN_W + 1)'(BUTTON_COUNT);
	assign table_full = used_q >= LINK_W'(ENTRY_CAPACITY);
	assign add_go     = accept && (req.func == FN_ADD) && in_range && !table_full;
	assign head_in    = in_range ? heads_q[req.button[HEAD_IDX_W-1:0]] : '0;

	// Walk helpers.
	assign cur_ok     = (cur_q != '0) && (cur_q <= LINK_W'(ENTRY_CAPACITY));
	assign new_link   = used_q + LINK_W'(1);
	assign subset_hit = ((mask_q & rd_data.mask) == rd_data.mask);
	assign out_free   = !out_valid_q || rsp.ready;

	// Popcount chain: the accepted mask enters the first cell directly.
	assign chain_tok[0] = '{v: add_go, cnt: '0, bits: req.modifier_mask};

	for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
		bcpm_pop_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain_tok[g]),
			.tok_out (chain_tok[g + 1])
		);
	end

	// Entry store requests.
	always_comb begin
		rd      = '0;
		rd.en   = (state_q == S_RD) && cur_ok;
		rd.addr = SLOT_W'(cur_q - LINK_W'(1));
		wr      = '0;
		if (state_q == S_INS_NEW) begin
			wr.en       = 1'b1;
			wr.addr     = used_q[SLOT_W-1:0];
			wr.ent.mask = mask_q;
			wr.ent.cmd  = cmd_q;
			wr.ent.pop  = bits_q;
			wr.ent.link = cur_q;
		end else if (state_q == S_INS_LINK) begin
			wr.en        = 1'b1;
			wr.link_only = 1'b1;
			wr.addr      = SLOT_W'(prev_q - LINK_W'(1));
			wr.ent.link  = new_link;
		end
	end

	bcpm_entry_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	// Request payload captured at acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= req.func;
			button_q <= req.button;
			mask_q   <= req.modifier_mask;
			cmd_q    <= req.command;
		end
		if (state_q == S_POP && chain_tok[CELL_COUNT].v) begin
			bits_q <= chain_tok[CELL_COUNT].cnt;
		end
	end

	// Sequencer, list heads and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_q     <= '0;
			prev_q    <= '0;
			used_q    <= '0;
			res_cmd_q <= '0;
			res_st_q  <= ST_OK;
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				heads_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cur_q     <= head_in;
						prev_q    <= '0;
						res_cmd_q <= '0;
						if (req.func == FN_ADD) begin
							if (add_go) begin
								state_q <= S_POP;
							end else begin
								res_st_q <= ST_FULL;
								state_q  <= S_DONE;
							end
						end else if (in_range) begin
							state_q <= S_RD;
						end else begin
							res_st_q <= ST_MISS;
							state_q  <= S_DONE;
						end
					end
				end
				S_POP: begin
					if (chain_tok[CELL_COUNT].v) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (cur_ok) begin
						state_q <= S_CHK;
					end else if (func_q == FN_ADD) begin
						state_q <= S_INS_NEW;
					end else begin
						res_st_q <= ST_MISS;
						state_q  <= S_DONE;
					end
				end
				S_CHK: begin
					if (func_q == FN_FIND) begin
						if (subset_hit) begin
							res_cmd_q <= rd_data.cmd;
							res_st_q  <= ST_OK;
							state_q   <= S_DONE;
						end else begin
							cur_q   <= rd_data.link;
							state_q <= S_RD;
						end
					end else if (bits_q < rd_data.pop) begin
						prev_q  <= cur_q;
						cur_q   <= rd_data.link;
						state_q <= S_RD;
					end else begin
						state_q <= S_INS_NEW;
					end
				end
				S_INS_NEW: begin
					if (prev_q == '0) begin
						heads_q[button_q[HEAD_IDX_W-1:0]] <= new_link;
						used_q   <= new_link;
						res_st_q <= ST_OK;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_INS_LINK;
					end
				end
				S_INS_LINK: begin
					used_q   <= new_link;
					res_st_q <= ST_OK;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: holds one response word until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_cmd_q <= res_cmd_q;
			out_st_q  <= res_st_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.found_command = out_cmd_q;
	assign rsp.status        = out_st_q;

	// The fill count never passes the pool size.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= LINK_W'(ENTRY_CAPACITY))
		else $error("entry fill count exceeds pool size");

	// A new entry is only written into a free slot.
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && !wr.link_only) |-> !table_full)
		else $error("new entry written while the pool is full");

	// An accepted word always starts work and leaves the idle state.
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted word did not start the sequencer");

	// A response word is only loaded from the finishing state.
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("response loaded outside the finishing state");

	// Only a find hit carries a non-zero command.
	a_cmd_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_cmd_q != '0) |-> (out_st_q == ST_OK))
		else $error("non-zero command with a miss or full status");
endmodule

### design/bcpm_pop_cell.sv
// One cell of the population count chain: adds the ones of the low slice of the mask
// to the running count and hands the rest of the mask on. Depends on bcpm_pkg.
module bcpm_pop_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  bcpm_pkg::pop_tok_t tok_in,
	output bcpm_pkg::pop_tok_t tok_out
);
	import bcpm_pkg::*;

	logic [POP_W-1:0]  slice_ones;
	logic              v_q;
	logic [POP_W-1:0]  cnt_q;
	logic [MASK_W-1:0] bits_q;

	// Count the ones in the slice this cell owns.
	always_comb begin
		slice_ones = '0;
		for (int i = 0; i < CELL_BITS; i++) begin
			slice_ones = slice_ones + POP_W'(tok_in.bits[i]);
		end
	end

	// The valid flag is control and is reset; the count and mask are payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= tok_in.v;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q  <= tok_in.cnt + slice_ones;
		bits_q <= tok_in.bits >> CELL_BITS;
	end

	assign tok_out = '{v: v_q, cnt: cnt_q, bits: bits_q};
endmodule

### design/bcpm_entry_store.sv
// Entry pool of the chord map: masks, commands, cached popcounts and list links,
// one write port and one registered read port. Depends on bcpm_pkg.
module bcpm_entry_store (
	input  logic              clk,
	input  bcpm_pkg::ent_wr_t wr,
	input  bcpm_pkg::ent_rd_t rd,
	output bcpm_pkg::entry_t  rd_data
);
	import bcpm_pkg::*;

	logic [MASK_W-1:0] mask_mem [ENTRY_CAPACITY];
	logic [CMD_W-1:0]  cmd_mem  [ENTRY_CAPACITY];
	logic [POP_W-1:0]  pop_mem  [ENTRY_CAPACITY];
	logic [LINK_W-1:0] link_mem [ENTRY_CAPACITY];
	entry_t            rd_q;

	// A full write stores a new entry; a link-only write relinks a predecessor.
	always_ff @(posedge clk) begin
		if (wr.en && !wr.link_only) begin
			mask_mem[wr.addr] <= wr.ent.mask;
			cmd_mem[wr.addr]  <= wr.ent.cmd;
			pop_mem[wr.addr]  <= wr.ent.pop;
		end
		if (wr.en) begin
			link_mem[wr.addr] <= wr.ent.link;
		end
	end

	// Registered read of one whole entry.
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_q.mask <= mask_mem[rd.addr];
			rd_q.cmd  <= cmd_mem[rd.addr];
			rd_q.pop  <= pop_mem[rd.addr];
			rd_q.link <= link_mem[rd.addr];
		end
	end

	assign rd_data = rd_q;
endmodule
